// ----- hdl/etl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package etl_pkg;

  // default identifier buffer depth
  localparam int MAX_IDENT_DEF = 32;

  // saturation limit of integer literals
  localparam logic [30:0] INT_SAT = 31'h7FFF_FFFF;

  // character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_T     = 8'h74;

  // operator codes
  localparam logic [2:0] OP_PLUS  = 3'd0;
  localparam logic [2:0] OP_MINUS = 3'd1;
  localparam logic [2:0] OP_MUL   = 3'd2;
  localparam logic [2:0] OP_DIV   = 3'd3;
  localparam logic [2:0] OP_POW   = 3'd4;

  typedef enum logic [3:0] {
    TK_INT    = 4'd0,
    TK_OP     = 4'd1,
    TK_LPAREN = 4'd2,
    TK_RPAREN = 4'd3,
    TK_SEMI   = 4'd4,
    TK_ASSIGN = 4'd5,
    TK_IDENT  = 4'd6,
    TK_KW_INT = 4'd7,
    TK_END    = 4'd8,
    TK_ERROR  = 4'd9
  } token_kind_t;

  typedef enum logic [2:0] {
    LM_START = 3'd0,
    LM_SKIP  = 3'd1,
    LM_NUM   = 3'd2,
    LM_IDENT = 3'd3,
    LM_COLON = 3'd4
  } lex_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_PEND    = 2'd1,
    ST_ID_EMIT = 2'd2
  } ctrl_state_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    token_kind_t token_kind;
    logic [30:0] int_value;
    logic [2:0]  op_code;
    logic [7:0]  ident_char;
    logic [4:0]  ident_pos;
    logic        ident_truncated;
    logic        last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic        cap_in;
    logic        acc_step;
    logic        acc_load;
    logic        id_append;
    logic        id_start;
    logic        rd_start;
    logic        id_adv;
    logic        out_load;
    token_kind_t out_kind;
    logic        out_last;
  } etl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic        out_free;
    logic        in_digit;
    logic        in_alpha;
    logic        q_eoi;
    logic        q_newline;
    logic        q_space;
    logic        q_digit;
    logic        q_alpha;
    logic        q_colon;
    logic        q_equal;
    token_kind_t q_kind;
    logic        kw_hit;
    logic        id_last;
  } etl_sts_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[CH_LA:CH_LZ], [CH_UA:CH_UZ]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {CH_SPACE, [CH_TAB:CH_CR]};
  endfunction

  // kind of a single character token, error for anything unknown
  function automatic token_kind_t char_kind(input logic [7:0] c);
    token_kind_t k;
    case (c)
      CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET: k = TK_OP;
      CH_LPAR: k = TK_LPAREN;
      CH_RPAR: k = TK_RPAREN;
      CH_SEMI: k = TK_SEMI;
      default: k = TK_ERROR;
    endcase
    return k;
  endfunction

  function automatic logic [2:0] op_code_of(input logic [7:0] c);
    logic [2:0] op;
    case (c)
      CH_MINUS: op = OP_MINUS;
      CH_STAR:  op = OP_MUL;
      CH_SLASH: op = OP_DIV;
      CH_CARET: op = OP_POW;
      default:  op = OP_PLUS;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/etl_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module etl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/etl_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module etl_dp
  import etl_pkg::*;
#(
  parameter int MAX_IDENT = MAX_IDENT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  etl_cmd_t  cmd,
  output etl_sts_t  sts,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int AW = $clog2(MAX_IDENT);
  localparam int LW = $clog2(MAX_IDENT + 1);

  in_item_t     in_q_r;
  logic [30:0]  acc_r, acc_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic         ovf_r, ovf_nxt;
  logic         kw_ok_r, kw_ok_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic         out_valid_r, out_valid_nxt;
  out_item_t    out_r, out_nxt;

  logic [34:0]  acc_wide;
  logic [34:0]  acc_prod;
  logic         ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]   ram_rdata;

  // decimal accumulate with saturation
  always_comb begin
    acc_wide = 35'(acc_r);
    acc_prod = (acc_wide << 3) + (acc_wide << 1) + 35'(in_data.char_code[3:0]);
  end

  // token state update
  always_comb begin
    acc_nxt   = acc_r;
    len_nxt   = len_r;
    ovf_nxt   = ovf_r;
    kw_ok_nxt = kw_ok_r;
    ram_we    = 1'b0;
    ram_waddr = AW'(len_r);
    ram_wdata = in_data.char_code;
    if (cmd.acc_step) begin
      acc_nxt = (acc_prod > 35'(INT_SAT)) ? INT_SAT : acc_prod[30:0];
    end else if (cmd.acc_load) begin
      acc_nxt = 31'(in_q_r.char_code - CH_ZERO);
    end
    if (cmd.id_append) begin
      if (len_r < LW'(MAX_IDENT)) begin
        ram_we  = 1'b1;
        len_nxt = len_r + LW'(1);
        if ((len_r == LW'(1) && in_data.char_code != CH_N) ||
            (len_r == LW'(2) && in_data.char_code != CH_T)) begin
          kw_ok_nxt = 1'b0;
        end
      end else begin
        ovf_nxt = 1'b1;
      end
    end else if (cmd.id_start) begin
      ram_we    = 1'b1;
      ram_waddr = '0;
      ram_wdata = in_q_r.char_code;
      len_nxt   = LW'(1);
      ovf_nxt   = 1'b0;
      kw_ok_nxt = (in_q_r.char_code == CH_I);
    end
  end

  // identifier read index, read runs one ahead of the emit
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.rd_start) begin
      idx_nxt = '0;
    end else if (cmd.id_adv) begin
      idx_nxt = idx_r + AW'(1);
    end
    ram_raddr = idx_nxt;
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (cmd.out_load) begin
      out_valid_nxt       = 1'b1;
      out_nxt             = '0;
      out_nxt.token_kind  = cmd.out_kind;
      out_nxt.last        = cmd.out_last;
      case (cmd.out_kind)
        TK_INT: out_nxt.int_value = acc_r;
        TK_OP:  out_nxt.op_code   = op_code_of(in_q_r.char_code);
        TK_IDENT: begin
          out_nxt.ident_char      = ram_rdata;
          out_nxt.ident_pos       = 5'(idx_r);
          out_nxt.ident_truncated = ovf_r;
        end
        default: ;
      endcase
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      in_q_r <= in_data;
    end
    kw_ok_r <= kw_ok_nxt;
    idx_r   <= idx_nxt;
    out_r   <= out_nxt;
  end

  etl_ram #(
    .WIDTH(8),
    .DEPTH(MAX_IDENT)
  ) u_ident_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // status back to the controller
  always_comb begin
    sts.out_free  = !out_valid_r || !out_stall;
    sts.in_digit  = is_digit(in_data.char_code);
    sts.in_alpha  = is_alpha(in_data.char_code);
    sts.q_eoi     = in_q_r.end_of_input;
    sts.q_newline = (in_q_r.char_code == CH_NL);
    sts.q_space   = is_space(in_q_r.char_code);
    sts.q_digit   = is_digit(in_q_r.char_code);
    sts.q_alpha   = is_alpha(in_q_r.char_code);
    sts.q_colon   = (in_q_r.char_code == CH_COLON);
    sts.q_equal   = (in_q_r.char_code == CH_EQUAL);
    sts.q_kind    = char_kind(in_q_r.char_code);
    sts.kw_hit    = kw_ok_r && !ovf_r && (len_r == LW'(3));
    sts.id_last   = ((LW'(idx_r) + LW'(1)) == len_r);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ----- hdl/etl_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module etl_ctrl
  import etl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  etl_sts_t sts,
  output etl_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;
  lex_mode_t   mode_r, mode_nxt;
  logic        eff_start;
  logic        start_emits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r  <= LM_START;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    cmd       = '0;
    in_stall  = (state_r != ST_IDLE);

    // does the token-start part of the held character give a result
    eff_start   = (mode_r != LM_SKIP);
    start_emits = sts.q_eoi || (sts.q_newline && eff_start) ||
                  !(sts.q_space || sts.q_digit || sts.q_alpha || sts.q_colon);

    case (state_r)
      // take a character; digits and letters inside a token are absorbed
      ST_IDLE: begin
        if (in_valid) begin
          if (mode_r == LM_NUM && !in_data.end_of_input && sts.in_digit) begin
            cmd.acc_step = 1'b1;
          end else if (mode_r == LM_IDENT && !in_data.end_of_input && sts.in_alpha) begin
            cmd.id_append = 1'b1;
          end else begin
            cmd.cap_in = 1'b1;
            state_nxt  = ST_PEND;
          end
        end
      end

      // finish the pending token, then handle the character as a token start unless it completes an assignment
      ST_PEND: begin
        case (mode_r)
          LM_NUM: begin
            if (sts.out_free) begin
              cmd.out_load = 1'b1;
              cmd.out_kind = TK_INT;
              cmd.out_last = !start_emits;
              mode_nxt     = LM_START;
            end
          end
          LM_IDENT: begin
            if (sts.kw_hit) begin
              if (sts.out_free) begin
                cmd.out_load = 1'b1;
                cmd.out_kind = TK_KW_INT;
                cmd.out_last = !start_emits;
                mode_nxt     = LM_START;
              end
            end else begin
              cmd.rd_start = 1'b1;
              mode_nxt     = LM_START;
              state_nxt    = ST_ID_EMIT;
            end
          end
          LM_COLON: begin
            if (sts.out_free) begin
              cmd.out_load = 1'b1;
              mode_nxt     = LM_START;
              if (!sts.q_eoi && sts.q_equal) begin
                cmd.out_kind = TK_ASSIGN;
                cmd.out_last = 1'b1;
                state_nxt    = ST_IDLE;
              end else begin
                cmd.out_kind = TK_ERROR;
                cmd.out_last = !start_emits;
              end
            end
          end
          default: begin
            if (sts.q_eoi || (sts.q_newline && eff_start)) begin
              if (sts.out_free) begin
                cmd.out_load = 1'b1;
                cmd.out_kind = TK_END;
                cmd.out_last = 1'b1;
                mode_nxt     = LM_START;
                state_nxt    = ST_IDLE;
              end
            end else if (sts.q_space) begin
              mode_nxt  = LM_SKIP;
              state_nxt = ST_IDLE;
            end else if (sts.q_digit) begin
              cmd.acc_load = 1'b1;
              mode_nxt     = LM_NUM;
              state_nxt    = ST_IDLE;
            end else if (sts.q_alpha) begin
              cmd.id_start = 1'b1;
              mode_nxt     = LM_IDENT;
              state_nxt    = ST_IDLE;
            end else if (sts.q_colon) begin
              mode_nxt  = LM_COLON;
              state_nxt = ST_IDLE;
            end else if (sts.out_free) begin
              cmd.out_load = 1'b1;
              cmd.out_kind = sts.q_kind;
              cmd.out_last = 1'b1;
              mode_nxt     = LM_START;
              state_nxt    = ST_IDLE;
            end
          end
        endcase
      end

      // one identifier character per transfer
      ST_ID_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = TK_IDENT;
          cmd.out_last = sts.id_last && !start_emits;
          cmd.id_adv   = 1'b1;
          if (sts.id_last) begin
            state_nxt = ST_PEND;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/expression_token_lexer_unit.sv -----
// Streaming lexer for arithmetic expressions.
// Input channel (in_valid / in_stall / in_data): one character byte per
// transfer, or an end-of-input mark. Output channel (out_valid / out_stall /
// out_data): one token per transfer; the last token caused by an input
// character carries last = 1, and a character may cause no token at all.
// A digit inside a number or a letter inside an identifier is absorbed as it
// is taken; any other character is captured into a holding register, closes
// any open token from there and, unless it completes an assignment, is then
// handled as a token start. Closing an identifier other than the keyword
// reads the identifier buffer RAM, whose single read port sends one buffered
// character per cycle while the output is not stalled. A held output stalls
// the token sequencer; a new character is taken once the previous one has
// been fully handled and the controller is idle again.
// Reset (rst_n low, synchronous) empties the output register and returns the
// lexer to token start, clearing the number accumulator and the identifier
// length and overflow flag.
`timescale 1ns / 1ps
`default_nettype none

module expression_token_lexer_unit
  import etl_pkg::*;
#(
  parameter int MAX_IDENT = MAX_IDENT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  etl_cmd_t cmd;
  etl_sts_t sts;

  etl_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .sts     (sts),
    .cmd     (cmd)
  );

  etl_dp #(
    .MAX_IDENT(MAX_IDENT)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  // a token never overwrites a result still waiting for transfer
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("token loaded over a waiting result");

  // absorbed letters never produce a token
  a_append_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.id_append |-> !cmd.out_load && !cmd.cap_in)
    else $error("identifier append with token output");

  // identifier run stops after its final character
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.id_adv && sts.id_last |=> !cmd.id_adv)
    else $error("identifier emit past its length");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import etl_pkg::*;

  localparam int RANDOM_ITEMS = 385;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;

  // token tracker: lexes the accepted characters and holds the tokens still owed
  class token_scoreboard;
    out_item_t   expected_tokens[$];
    out_item_t   step_tokens[$];
    lex_mode_t   mode;
    logic [30:0] num_acc;
    logic [7:0]  word_buf[MAX_IDENT_DEF];
    int          word_len;
    bit          word_cut;
    int          mismatches;
    int          checked;

    function new();
      mode       = LM_START;
      num_acc    = '0;
      word_len   = 0;
      word_cut   = 1'b0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function bit digit_char(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function bit letter_char(input logic [7:0] c);
      return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
    endfunction

    function bit blank_char(input logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function void emit(input token_kind_t kind, input logic [30:0] ival = '0,
                       input logic [2:0] op = '0, input logic [7:0] ch = '0,
                       input logic [4:0] pos = '0, input logic trunc = 1'b0);
      out_item_t t;
      t.token_kind      = kind;
      t.int_value       = ival;
      t.op_code         = op;
      t.ident_char      = ch;
      t.ident_pos       = pos;
      t.ident_truncated = trunc;
      t.last            = 1'b0;
      step_tokens.push_back(t);
    endfunction

    // buffered word goes out as keyword or as a run of characters
    function void flush_word();
      if (!word_cut && word_len == 3 && word_buf[0] == CH_I && word_buf[1] == CH_N &&
          word_buf[2] == CH_T) begin
        emit(TK_KW_INT);
        return;
      end
      for (int i = 0; i < word_len; i++)
        emit(TK_IDENT, '0, '0, word_buf[i], 5'(i), word_cut);
    endfunction

    // one character of lexing, tokens collected in step_tokens
    function void lex_char(input in_item_t it);
      logic [7:0]  c;
      bit          eoi;
      logic [63:0] v;
      c   = it.char_code;
      eoi = it.end_of_input;

      // close whatever token is open
      case (mode)
        LM_NUM: begin
          if (!eoi && digit_char(c)) begin
            v = 64'(num_acc) * 10 + 64'(c - CH_ZERO);
            num_acc = (v > 64'(INT_SAT)) ? INT_SAT : v[30:0];
            return;
          end
          emit(TK_INT, num_acc);
          mode = LM_START;
        end
        LM_IDENT: begin
          if (!eoi && letter_char(c)) begin
            if (word_len < MAX_IDENT_DEF) begin
              word_buf[word_len] = c;
              word_len++;
            end else begin
              word_cut = 1'b1;
            end
            return;
          end
          flush_word();
          mode = LM_START;
        end
        LM_COLON: begin
          mode = LM_START;
          if (!eoi && c == CH_EQUAL) begin
            emit(TK_ASSIGN);
            return;
          end
          emit(TK_ERROR);
        end
        LM_SKIP: ;
        default: mode = LM_START;
      endcase

      // start of the next token
      if (eoi) begin
        emit(TK_END);
        mode = LM_START;
      end else if (c == CH_NL && mode == LM_START) begin
        emit(TK_END);
      end else if (blank_char(c)) begin
        mode = LM_SKIP;
      end else begin
        mode = LM_START;
        if (digit_char(c)) begin
          num_acc = 31'(c - CH_ZERO);
          mode    = LM_NUM;
        end else if (letter_char(c)) begin
          word_buf[0] = c;
          word_len    = 1;
          word_cut    = 1'b0;
          mode        = LM_IDENT;
        end else begin
          case (c)
            CH_PLUS:  emit(TK_OP, '0, OP_PLUS);
            CH_MINUS: emit(TK_OP, '0, OP_MINUS);
            CH_STAR:  emit(TK_OP, '0, OP_MUL);
            CH_SLASH: emit(TK_OP, '0, OP_DIV);
            CH_CARET: emit(TK_OP, '0, OP_POW);
            CH_LPAR:  emit(TK_LPAREN);
            CH_RPAR:  emit(TK_RPAREN);
            CH_SEMI:  emit(TK_SEMI);
            CH_COLON: mode = LM_COLON;
            default:  emit(TK_ERROR);
          endcase
        end
      end
    endfunction

    // accepted input: predict its tokens and queue them
    function void note_char(input in_item_t it);
      out_item_t t;
      step_tokens.delete();
      lex_char(it);
      foreach (step_tokens[i]) begin
        t      = step_tokens[i];
        t.last = (i == step_tokens.size() - 1);
        expected_tokens.push_back(t);
      end
    endfunction

    task report(input string what);
      mismatches++;
      if (mismatches <= 40) $display("mismatch %0d: %s", mismatches, what);
    endtask

    task compare_field(input string name, input longint unsigned got,
                       input longint unsigned want);
      if (got != want)
        report($sformatf("token %0d %s: got %0d, expected %0d", checked, name, got, want));
    endtask

    // accepted token: compare against the oldest owed one
    task check_token(input out_item_t got);
      out_item_t want;
      if (expected_tokens.size() == 0) begin
        report($sformatf("token of kind %0d with none owed", got.token_kind));
        return;
      end
      want = expected_tokens.pop_front();
      checked++;
      compare_field("token_kind", got.token_kind, want.token_kind);
      compare_field("int_value", got.int_value, want.int_value);
      compare_field("op_code", got.op_code, want.op_code);
      compare_field("ident_char", got.ident_char, want.ident_char);
      compare_field("ident_pos", got.ident_pos, want.ident_pos);
      compare_field("ident_truncated", got.ident_truncated, want.ident_truncated);
      compare_field("last", got.last, want.last);
    endtask

    task report_leftovers();
      foreach (expected_tokens[i])
        report($sformatf("token of kind %0d never arrived", expected_tokens[i].token_kind));
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int idle_pct    = 0;
  int stall_pct   = 0;
  int sent        = 0;
  int quiet_count = 0;

  token_scoreboard sb = new();

  always #5 clk = ~clk;

  expression_token_lexer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // random back-pressure on the token side
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // transfer monitor on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_char(in_data);
      if (out_valid && !out_stall) sb.check_token(out_data);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_count = 0;
      else quiet_count++;
      if (quiet_count >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // one character transfer, with a random gap in front
  task automatic send_char(input logic [7:0] c, input logic eoi = 1'b0);
    in_item_t item;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    item.char_code    = c;
    item.end_of_input = eoi;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_number(input int len);
    repeat (len) send_char(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic send_word(input int len);
    repeat (len)
      send_char($urandom_range(0, 1) ? CH_LA + 8'($urandom_range(0, 25))
                                     : CH_UA + 8'($urandom_range(0, 25)));
  endtask

  // sender holds off until every owed token has come out
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.expected_tokens.size() != 0) @(negedge clk);
  endtask

  // one random token, mostly well formed
  task automatic send_token();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      send_number(($urandom_range(0, 9) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 5));
    end else if (pick < 40) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          send_char(CH_I);
          send_char(CH_N);
          send_char(CH_T);
        end
        2: send_word($urandom_range(MAX_IDENT_DEF - 1, MAX_IDENT_DEF + 6));
        3: begin
          send_char(CH_I);
          send_char(CH_N);
          send_word($urandom_range(0, 2));
        end
        default: send_word($urandom_range(1, 8));
      endcase
    end else if (pick < 54) begin
      case ($urandom_range(0, 4))
        0: send_char(CH_PLUS);
        1: send_char(CH_MINUS);
        2: send_char(CH_STAR);
        3: send_char(CH_SLASH);
        default: send_char(CH_CARET);
      endcase
    end else if (pick < 62) begin
      send_char($urandom_range(0, 1) ? CH_LPAR : CH_RPAR);
    end else if (pick < 66) begin
      send_char(CH_SEMI);
    end else if (pick < 71) begin
      send_char(CH_COLON);
      send_char(CH_EQUAL);
    end else if (pick < 74) begin
      send_char(CH_COLON);
    end else if (pick < 84) begin
      repeat ($urandom_range(1, 3))
        send_char(($urandom_range(0, 5) == 0) ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4)));
    end else if (pick < 90) begin
      send_char(CH_NL);
    end else if (pick < 94) begin
      send_char(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      send_char(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    string opening;
    int    target;
    opening  = "\n \n(7+-*/^);x:=int:a";
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed opening: newline rules, every operator, assign, keyword, lone colons
    for (int i = 0; i < opening.len(); i++) send_char(opening[i]);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CH_COLON);
    send_char(8'hFF, 1'b1);
    send_char(CH_NINE);
    send_char(8'h00, 1'b1);
    pause_until_drained();

    // random phases with different idling and back-pressure
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct = 76;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 76;
        end
        default: begin
          idle_pct = 10;
          stall_pct <= 10;
        end
      endcase
      target = sent + RANDOM_ITEMS / 4;
      // an over-long identifier and an eleven-digit literal that can saturate
      if (phase == 1) begin
        send_word(MAX_IDENT_DEF + 3);
        send_char(CH_SEMI);
        send_number(11);
        send_char(CH_SEMI);
      end
      while (sent < target) send_token();
      pause_until_drained();
    end

    // let any stray tokens show up
    stall_pct <= 0;
    repeat (DRAIN_CYCLES) @(negedge clk);
    sb.report_leftovers();
    if (sb.mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
